>>> rtl/core/bmt_pkg.sv
// ----------------------------------------------------------------------------
// bmt_pkg: shared types and constants of the bounded multiset table
// Sizes of the table, operation codes and the query word that runs the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bmt_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int KIND_W      = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD        = 3'd0,
      KIND_ADD_UNIQUE = 3'd1,
      KIND_REMOVE     = 3'd2,
      KIND_COUNT      = 3'd3,
      KIND_CLEAR      = 3'd4
   } kind_type;

   // query word handed from cell to cell, one cell per cycle
   typedef struct packed {
      logic                   valid;
      kind_type               kind;
      logic [VALUE_WIDTH-1:0] value;
      logic [CNT_W-1:0]       count;    // table size when the query entered
      logic [CNT_W-1:0]       pos;      // index of the cell it is visiting
      logic [CNT_W-1:0]       hits;     // live hits seen so far
      logic                   found;    // remove: hole opened at an earlier cell
      logic                   added;    // append took place
   } tok_type;

   typedef struct packed {
      logic             success;
      logic [CNT_W-1:0] match_count;
      logic             present;
      logic [CNT_W-1:0] size;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/bmt_cell.sv
// ----------------------------------------------------------------------------
// bmt_cell: one entry of the table
// Holds an entry, compares it with the passing query, appends, and takes its
// right neighbor's entry while a remove closes the hole.
// ----------------------------------------------------------------------------
`default_nettype none

module bmt_cell import bmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  tok_type                tok_i,
   output tok_type                tok_o,
   input  logic [VALUE_WIDTH-1:0] right_entry_i,
   input  logic                   shift_i,
   output logic [VALUE_WIDTH-1:0] entry_o,
   output logic                   shift_o
);

   logic [VALUE_WIDTH-1:0] entry_ff, entry_in;
   tok_type                tok_ff, tok_in;
   logic                   live, hit, append;

   always_comb begin
      live   = tok_i.pos < tok_i.count;
      hit    = tok_i.valid && live && (entry_ff == tok_i.value);
      // every live cell lies before pos == count, so hits is final here
      append = tok_i.valid && (tok_i.pos == tok_i.count) &&
               ((tok_i.kind == KIND_ADD) ||
                ((tok_i.kind == KIND_ADD_UNIQUE) && (tok_i.hits == '0)));

      tok_in     = tok_i;
      tok_in.pos = tok_i.pos + CNT_W'(1);
      if (hit) begin
         tok_in.hits = tok_i.hits + CNT_W'(1);
      end
      if ((tok_i.kind == KIND_REMOVE) && hit && !tok_i.found) begin
         tok_in.found = 1'b1;
      end
      if (append) begin
         tok_in.added = 1'b1;
      end

      // hole lies to the left: hand this entry down one place
      shift_o = tok_i.valid && (tok_i.kind == KIND_REMOVE) && tok_i.found;

      entry_in = entry_ff;
      if (append) begin
         entry_in = tok_i.value;
      end else if (shift_i) begin
         entry_in = right_entry_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o   = tok_ff;
   assign entry_o = entry_ff;

endmodule

`default_nettype wire

>>> rtl/core/bmt_ctrl.sv
// ----------------------------------------------------------------------------
// bmt_ctrl: request intake, size register and response register
// Launches one query into the chain, folds the returning query into a
// response and keeps the table size.
// ----------------------------------------------------------------------------
`default_nettype none

module bmt_ctrl import bmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output tok_type                head_o,
   input  tok_type                tail_i,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_o
);

   logic             busy_ff, busy_in;
   logic             fin_valid_ff, fin_valid_in;
   rsp_type          fin_ff, fin_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept, move;
   logic [CNT_W-1:0] new_matches;

   always_comb begin
      accept = req_valid && !busy_ff;
      move   = fin_valid_ff && (!rsp_valid_ff || !rsp_stall);

      head_o.valid = accept;
      head_o.kind  = kind_type'(req_kind);
      head_o.value = req_value;
      head_o.count = count_ff;
      head_o.pos   = '0;
      head_o.hits  = '0;
      head_o.found = 1'b0;
      head_o.added = 1'b0;

      count_in     = count_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff;
      new_matches  = tail_i.hits;

      if (tail_i.valid) begin
         fin_in.success = 1'b0;
         case (tail_i.kind)
            KIND_ADD, KIND_ADD_UNIQUE: begin
               fin_in.success = tail_i.added;
               count_in       = tail_i.count + CNT_W'(tail_i.added);
               new_matches    = tail_i.hits + CNT_W'(tail_i.added);
            end
            KIND_REMOVE: begin
               fin_in.success = tail_i.found;
               count_in       = tail_i.count - CNT_W'(tail_i.found);
               new_matches    = tail_i.hits - CNT_W'(tail_i.found);
            end
            KIND_COUNT: begin
               fin_in.success = 1'b1;
            end
            KIND_CLEAR: begin
               fin_in.success = 1'b1;
               count_in       = '0;
               new_matches    = '0;
            end
            default: begin
               fin_in.success = 1'b0;
            end
         endcase
         fin_in.match_count = new_matches;
         fin_in.present     = new_matches != '0;
         fin_in.size        = count_in;
         fin_valid_in       = 1'b1;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      busy_in      = busy_ff || accept;
      if (move) begin
         rsp_in       = fin_ff;
         rsp_valid_in = 1'b1;
         fin_valid_in = 1'b0;
         busy_in      = 1'b0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_o     = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/core/bounded_multiset_table.sv
// ----------------------------------------------------------------------------
// bounded_multiset_table: fixed-capacity unordered multiset of data words
// Add, add-unique, remove, count and clear on a row of entry cells; each
// request word yields one response word.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_kind, req_value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_success, rsp_match_count,
//           |           |                     | rsp_present, rsp_size
//
// A request walks the row of CAPACITY cells, one cell a cycle, then passes a
// result stage and the response register. A new request is taken once the
// previous one has reached the response register.
// Synchronous reset empties the table at once; entries are not cleared.
// A stalled response holds; the next request still runs through the row.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_multiset_table import bmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_success,
   output logic [CNT_W-1:0]       rsp_match_count,
   output logic                   rsp_present,
   output logic [CNT_W-1:0]       rsp_size
);

   tok_type                tok_chain [CAPACITY+1];
   logic [VALUE_WIDTH-1:0] ent       [1:CAPACITY];
   logic                   sh        [1:CAPACITY];
   rsp_type                rsp;

   bmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_value (req_value),
      .head_o    (tok_chain[0]),
      .tail_i    (tok_chain[CAPACITY]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_o     (rsp)
   );

   // nothing to the right of the last cell
   assign ent[CAPACITY] = '0;
   assign sh[CAPACITY]  = 1'b0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      if (k == 0) begin : g_first
         bmt_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .tok_i         (tok_chain[k]),
            .tok_o         (tok_chain[k+1]),
            .right_entry_i (ent[k+1]),
            .shift_i       (sh[k+1]),
            .entry_o       (),
            .shift_o       ()
         );
      end else begin : g_rest
         bmt_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .tok_i         (tok_chain[k]),
            .tok_o         (tok_chain[k+1]),
            .right_entry_i (ent[k+1]),
            .shift_i       (sh[k+1]),
            .entry_o       (ent[k]),
            .shift_o       (sh[k])
         );
      end
   end

   assign rsp_success     = rsp.success;
   assign rsp_match_count = rsp.match_count;
   assign rsp_present     = rsp.present;
   assign rsp_size        = rsp.size;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a query is in flight");

   a_tail_only_busy: assert property (@(posedge clock) disable iff (reset)
      tok_chain[CAPACITY].valid |-> req_stall)
      else $error("query left the row with no request outstanding");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_size <= CNT_W'(CAPACITY)) && (rsp_match_count <= rsp_size)))
      else $error("response size or match count out of range");

   a_present_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_present == (rsp_match_count != '0)))
      else $error("present flag disagrees with match count");
`endif

endmodule

`default_nettype wire
